/* src/cwrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwrc_pkg
// Shared widths, constants, event codes and inter-stage structs for the
// congestion window and retransmit timeout controller.
// ----------------------------------------------------------------------------
package cwrc_pkg;

  // Field and state widths.
  localparam int WINDOW_WIDTH = 16;
  localparam int RTT_WIDTH    = 24;
  localparam int SEQ_WIDTH    = 25;
  localparam int COUNT_WIDTH  = 24;
  localparam int MODE_WIDTH   = 2;
  localparam int RTO_WIDTH    = 22;
  localparam int MS_WIDTH     = 12;

  // Beat widths on the stream ports.
  localparam int IN_DATA_WIDTH  = 72;
  localparam int OUT_DATA_WIDTH = 80;

  // Window constants.
  localparam logic [WINDOW_WIDTH-1:0] WIN_MAX        = '1;
  localparam logic [WINDOW_WIDTH-1:0] INIT_WINDOW    = WINDOW_WIDTH'(1);
  localparam logic [WINDOW_WIDTH-1:0] INIT_THRESHOLD = WINDOW_WIDTH'(64);
  localparam logic [WINDOW_WIDTH-1:0] INIT_PEER      = WINDOW_WIDTH'(64);
  localparam logic [WINDOW_WIDTH-1:0] MIN_THRESHOLD  = WINDOW_WIDTH'(2);

  // Timeout limits in microseconds.
  localparam logic [RTO_WIDTH-1:0] RTO_MIN_US = RTO_WIDTH'(200000);
  localparam logic [RTO_WIDTH-1:0] RTO_MAX_US = RTO_WIDTH'(3000000);

  // Divide by 1000 as a multiply by ceil(2^32 / 1000) and a shift by 32.
  // The rounding error stays below one step for any value under 2^22.
  localparam int RECIP_WIDTH = 23;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = RECIP_WIDTH'(4294968);

  // Event kinds.
  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_START = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_LOSS  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // One input event as held in the input register.
  typedef struct packed {
    logic [MODE_WIDTH-1:0]   mode;
    logic [SEQ_WIDTH-1:0]    ack_seq;
    logic [WINDOW_WIDTH-1:0] rx_window;
    logic [RTT_WIDTH-1:0]    rtt_sample_us;
  } event_t;

  // Window fields of one result.
  typedef struct packed {
    logic [WINDOW_WIDTH-1:0] window_now;
    logic [WINDOW_WIDTH-1:0] threshold_now;
    logic [WINDOW_WIDTH-1:0] peer_window_now;
    logic [WINDOW_WIDTH-1:0] send_window;
  } cong_result_t;

  // Estimator snapshot taken after the event.
  typedef struct packed {
    logic [RTT_WIDTH-1:0] smoothed_rtt;
    logic [RTT_WIDTH-1:0] rtt_variance;
  } rtt_snap_t;

endpackage

/* src/congestion_window_rto_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_window_rto_controller_core
// Sender-side congestion window and retransmit timeout controller.
// ----------------------------------------------------------------------------
// Pipeline: an accepted event beat passes the input register, state update,
// timeout clamp and millisecond conversion before it leaves as a result beat.
// Throughput: one event per cycle when the result stream does not stall.
// Each stage moves when the one after it is empty or moving.
// Reset (rst, synchronous): pipeline emptied, window 1, threshold 64,
// peer window 64, estimator cleared, segment count 0.
module congestion_window_rto_controller_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration: segment count of the transfer.
  input  logic                                  cfg_we,
  input  logic [cwrc_pkg::COUNT_WIDTH-1:0]      cfg_wdata,
  // Event stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tdata: ack_seq[24:0], rx_window[40:25], rtt_sample_us[64:41], zero pad
  input  logic [cwrc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  // tuser: mode[1:0]
  input  logic [cwrc_pkg::MODE_WIDTH-1:0]       s_tuser,
  // Result stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // tdata: window_now[15:0], threshold_now[31:16], peer_window_now[47:32],
  //        send_window[63:48], timeout_ms[75:64], zero pad
  output logic [cwrc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata
);

  localparam int PAD_WIDTH = cwrc_pkg::OUT_DATA_WIDTH - 4*cwrc_pkg::WINDOW_WIDTH
                           - cwrc_pkg::MS_WIDTH;

  logic                   valid_a, valid_b, valid_c, valid_d;
  logic                   load_a, load_b, load_c, load_d;
  cwrc_pkg::event_t       evt_a;
  cwrc_pkg::cong_result_t res_b, res_c, res_d;
  cwrc_pkg::rtt_snap_t    snap_b;
  logic [cwrc_pkg::RTO_WIDTH-1:0] rto_c;
  logic [cwrc_pkg::MS_WIDTH-1:0]  ms_d;

  // Stage enables: a stage loads when it is empty or its beat moves on.
  assign load_d   = !valid_d || m_tready;
  assign load_c   = !valid_c || load_d;
  assign load_b   = !valid_b || load_c;
  assign load_a   = !valid_a || load_b;
  assign s_tready = load_a;

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (load_a) valid_a <= s_tvalid;
      if (load_b) valid_b <= valid_a;
      if (load_c) valid_c <= valid_b;
      if (load_d) valid_d <= valid_c;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (load_a) begin
      evt_a.mode          <= s_tuser;
      evt_a.ack_seq       <= s_tdata[24:0];
      evt_a.rx_window     <= s_tdata[40:25];
      evt_a.rtt_sample_us <= s_tdata[64:41];
    end
  end

  cwrc_cong_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .upd       (valid_a && load_b),
    .load      (load_b),
    .evt       (evt_a),
    .res       (res_b),
    .snap      (snap_b)
  );

  cwrc_rto_calc u_rto (
    .clk     (clk),
    .load    (load_c),
    .res_in  (res_b),
    .snap    (snap_b),
    .res_out (res_c),
    .rto_us  (rto_c)
  );

  cwrc_ms_convert u_ms (
    .clk        (clk),
    .load       (load_d),
    .res_in     (res_c),
    .rto_us     (rto_c),
    .res_out    (res_d),
    .timeout_ms (ms_d)
  );

  // Result beat.
  assign m_tvalid = valid_d;
  assign m_tdata  = {{PAD_WIDTH{1'b0}}, ms_d, res_d.send_window, res_d.peer_window_now,
                     res_d.threshold_now, res_d.window_now};

endmodule

/* src/cwrc_cong_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwrc_cong_state
// Holds the congestion and RTT estimator state, applies one event per cycle
// unless stalled, and registers the window fields and estimator snapshot.
// ----------------------------------------------------------------------------
module cwrc_cong_state (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cwrc_pkg::COUNT_WIDTH-1:0]    cfg_wdata,
  input  logic                                upd,
  input  logic                                load,
  input  cwrc_pkg::event_t                    evt,
  output cwrc_pkg::cong_result_t              res,
  output cwrc_pkg::rtt_snap_t                 snap
);

  logic [cwrc_pkg::COUNT_WIDTH-1:0]  data_packet_count;
  logic [cwrc_pkg::RTT_WIDTH-1:0]    smoothed_rtt, smoothed_rtt_next;
  logic [cwrc_pkg::RTT_WIDTH-1:0]    rtt_variance, rtt_variance_next;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] congestion_window, congestion_window_next;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] slow_start_threshold, slow_start_threshold_next;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] avoidance_ack_count, avoidance_ack_count_next;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] peer_window, peer_window_next;

  logic [cwrc_pkg::RTT_WIDTH-1:0]    rtt_diff;
  logic [cwrc_pkg::RTT_WIDTH+1:0]    var_sum;
  logic [cwrc_pkg::RTT_WIDTH+2:0]    srtt_sum;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] ack_count_inc;
  logic [cwrc_pkg::WINDOW_WIDTH-1:0] half_window;
  logic                              data_ack;

  // Estimator arithmetic for an ACK, using the old smoothed value.
  always_comb begin
    rtt_diff = (smoothed_rtt >= evt.rtt_sample_us) ? (smoothed_rtt - evt.rtt_sample_us)
                                                   : (evt.rtt_sample_us - smoothed_rtt);
    var_sum  = {1'b0, rtt_variance, 1'b0} + {2'b00, rtt_variance} + {2'b00, rtt_diff};
    srtt_sum = {smoothed_rtt, 3'b000} - {3'b000, smoothed_rtt}
             + {3'b000, evt.rtt_sample_us};
  end

  // Helpers for window growth and loss.
  assign data_ack      = (evt.ack_seq != '0) &&
                         (evt.ack_seq <= {1'b0, data_packet_count});
  assign ack_count_inc = (avoidance_ack_count < cwrc_pkg::WIN_MAX) ?
                         avoidance_ack_count + 1'b1 : avoidance_ack_count;
  assign half_window   = congestion_window >> 1;

  // Next state for the event in the input register.
  always_comb begin
    smoothed_rtt_next         = smoothed_rtt;
    rtt_variance_next         = rtt_variance;
    congestion_window_next    = congestion_window;
    slow_start_threshold_next = slow_start_threshold;
    avoidance_ack_count_next  = avoidance_ack_count;
    peer_window_next          = peer_window;
    if (upd) begin
      case (cwrc_pkg::mode_t'(evt.mode))
        cwrc_pkg::MODE_START: begin
          congestion_window_next    = cwrc_pkg::INIT_WINDOW;
          slow_start_threshold_next = cwrc_pkg::INIT_THRESHOLD;
          avoidance_ack_count_next  = '0;
          peer_window_next          = cwrc_pkg::INIT_PEER;
        end
        cwrc_pkg::MODE_ACK: begin
          // A zero estimate means no sample has been taken yet.
          if (smoothed_rtt == '0) begin
            smoothed_rtt_next = evt.rtt_sample_us;
            rtt_variance_next = evt.rtt_sample_us >> 1;
          end else begin
            rtt_variance_next = var_sum[cwrc_pkg::RTT_WIDTH+1:2];
            smoothed_rtt_next = srtt_sum[cwrc_pkg::RTT_WIDTH+2:3];
          end
          peer_window_next = evt.rx_window;
          // Only acknowledgments of data segments grow the window.
          if (data_ack) begin
            if (congestion_window < slow_start_threshold) begin
              if (congestion_window < cwrc_pkg::WIN_MAX) begin
                congestion_window_next = congestion_window + 1'b1;
              end
            end else if (ack_count_inc >= congestion_window) begin
              if (congestion_window < cwrc_pkg::WIN_MAX) begin
                congestion_window_next = congestion_window + 1'b1;
              end
              avoidance_ack_count_next = '0;
            end else begin
              avoidance_ack_count_next = ack_count_inc;
            end
          end
        end
        cwrc_pkg::MODE_LOSS: begin
          slow_start_threshold_next = (half_window > cwrc_pkg::MIN_THRESHOLD) ?
                                      half_window : cwrc_pkg::MIN_THRESHOLD;
          congestion_window_next    = cwrc_pkg::INIT_WINDOW;
          avoidance_ack_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_packet_count    <= '0;
      smoothed_rtt         <= '0;
      rtt_variance         <= '0;
      congestion_window    <= cwrc_pkg::INIT_WINDOW;
      slow_start_threshold <= cwrc_pkg::INIT_THRESHOLD;
      avoidance_ack_count  <= '0;
      peer_window          <= cwrc_pkg::INIT_PEER;
    end else begin
      if (cfg_we) begin
        data_packet_count <= cfg_wdata;
      end
      smoothed_rtt         <= smoothed_rtt_next;
      rtt_variance         <= rtt_variance_next;
      congestion_window    <= congestion_window_next;
      slow_start_threshold <= slow_start_threshold_next;
      avoidance_ack_count  <= avoidance_ack_count_next;
      peer_window          <= peer_window_next;
    end
  end

  // Result register: the state as it stands after the event.
  always_ff @(posedge clk) begin
    if (load) begin
      res.window_now      <= congestion_window_next;
      res.threshold_now   <= slow_start_threshold_next;
      res.peer_window_now <= peer_window_next;
      res.send_window     <= (congestion_window_next < peer_window_next) ?
                             congestion_window_next : peer_window_next;
      snap.smoothed_rtt   <= smoothed_rtt_next;
      snap.rtt_variance   <= rtt_variance_next;
    end
  end

endmodule

/* src/cwrc_rto_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwrc_rto_calc
// Forms the retransmit timeout from the estimator snapshot and clamps it
// to its limits, then registers it with the window fields.
// ----------------------------------------------------------------------------
module cwrc_rto_calc (
  input  logic                               clk,
  input  logic                               load,
  input  cwrc_pkg::cong_result_t             res_in,
  input  cwrc_pkg::rtt_snap_t                snap,
  output cwrc_pkg::cong_result_t             res_out,
  output logic [cwrc_pkg::RTO_WIDTH-1:0]     rto_us
);

  logic [cwrc_pkg::RTT_WIDTH+2:0] rto_sum;
  logic [cwrc_pkg::RTO_WIDTH-1:0] rto_clamped;

  // Smoothed estimate plus four times the variance, then the clamp.
  always_comb begin
    rto_sum = {3'b000, snap.smoothed_rtt} + {1'b0, snap.rtt_variance, 2'b00};
    if (rto_sum < {{(cwrc_pkg::RTT_WIDTH+3-cwrc_pkg::RTO_WIDTH){1'b0}},
                   cwrc_pkg::RTO_MIN_US}) begin
      rto_clamped = cwrc_pkg::RTO_MIN_US;
    end else if (rto_sum > {{(cwrc_pkg::RTT_WIDTH+3-cwrc_pkg::RTO_WIDTH){1'b0}},
                            cwrc_pkg::RTO_MAX_US}) begin
      rto_clamped = cwrc_pkg::RTO_MAX_US;
    end else begin
      rto_clamped = rto_sum[cwrc_pkg::RTO_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
      rto_us  <= rto_clamped;
    end
  end

endmodule

/* src/cwrc_ms_convert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwrc_ms_convert
// Converts the timeout from microseconds to whole milliseconds with a
// reciprocal multiply and registers the finished result.
// ----------------------------------------------------------------------------
module cwrc_ms_convert (
  input  logic                               clk,
  input  logic                               load,
  input  cwrc_pkg::cong_result_t             res_in,
  input  logic [cwrc_pkg::RTO_WIDTH-1:0]     rto_us,
  output cwrc_pkg::cong_result_t             res_out,
  output logic [cwrc_pkg::MS_WIDTH-1:0]      timeout_ms
);

  logic [cwrc_pkg::RTO_WIDTH+cwrc_pkg::RECIP_WIDTH-1:0] product;

  // Truncating divide by 1000.
  assign product = {{cwrc_pkg::RECIP_WIDTH{1'b0}}, rto_us} *
                   {{cwrc_pkg::RTO_WIDTH{1'b0}}, cwrc_pkg::RECIP_1000};

  always_ff @(posedge clk) begin
    if (load) begin
      res_out    <= res_in;
      timeout_ms <= product[cwrc_pkg::RECIP_SHIFT +: cwrc_pkg::MS_WIDTH];
    end
  end

endmodule

/* src/cwrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwrc_checker
// Port-level checks on the result stream of the controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module cwrc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [cwrc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata
);

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // The timeout always lies within its clamp limits.
  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[75:64] >= 12'd200) && (m_tdata[75:64] <= 12'd3000))
    else $error("timeout outside its limits");

  // The send window is the smaller of the two windows.
  a_send_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:48] == ((m_tdata[15:0] < m_tdata[47:32]) ?
                                     m_tdata[15:0] : m_tdata[47:32])))
    else $error("send window is not the minimum");

  // Window never drops to zero and threshold never below two.
  a_window_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'd0) && (m_tdata[31:16] >= 16'd2))
    else $error("window or threshold below its floor");

endmodule

bind congestion_window_rto_controller_core cwrc_checker u_cwrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
